// File: sv/cv3_pkg.sv
`default_nettype none

package cv3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int PIXEL_W    = 8;
    localparam int RESULT_W   = 16;
    localparam int COEF_W     = 8;
    localparam int KERNEL_DIM = 3;
    localparam int TAPS       = KERNEL_DIM * KERNEL_DIM;
    localparam int DIM_W      = 11;
    localparam int CFG_DATA_W = KERNEL_DIM * COEF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int MIN_DIM    = 3;
    localparam int DIM_RESET  = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_TOP   = 3'd0,
        CFG_KERNEL_MID   = 3'd1,
        CFG_KERNEL_BOT   = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } t_cfg_idx;

endpackage

`default_nettype wire

// File: sv/cv3_pixel_if.sv
`default_nettype none

interface cv3_pixel_if;
    import cv3_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// File: sv/cv3_result_if.sv
`default_nettype none

interface cv3_result_if;
    import cv3_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] filtered;
    logic                       frame_done;

    modport source (output valid, output filtered, output frame_done, input ready);
    modport sink   (input valid, input filtered, input frame_done, output ready);
endinterface

`default_nettype wire

// File: sv/cv3_ram.sv
`default_nettype none

module cv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/conv3x3_valid_filter.sv
`default_nettype none

// 3x3 valid-window convolution over an 8-bit grayscale raster stream.
//
// i_pix (valid/ready) takes one pixel per transfer in raster order. o_res
// (valid/ready) gives one signed 16-bit weighted sum per window that lies
// wholly inside the frame, with frame_done set on the last one of a frame.
// Pixels of the first two rows and columns of a row give no result. The
// user must write the config port (i_cfg_we/i_cfg_idx/i_cfg_wdata) only
// while idle; the block does not enforce it. Indexes 0..2 hold the kernel
// rows (column 0 in the low byte), 3 and 4 the frame width and height; a
// size write restarts the frame.
//
// Sustained rate is one pixel per clock while the receiver is ready. Each
// pixel transfer passes registered stages in order: the line-buffer RAM
// read, the nine products, then the adder tree into the output register.
// The two previous rows share one RAM (width 16, depth MAX_WIDTH) that is
// read when a pixel is taken and written when it moves to the product stage.
// While the receiver stalls the stages keep filling; i_pix.ready drops once
// every stage holds an item. Reset clears counts, window, kernel and sets
// both frame sizes to 1024; the line RAM needs no clearing.

module conv3x3_valid_filter #(
    parameter int MAX_WIDTH  = cv3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cv3_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cv3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cv3_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    cv3_pixel_if.sink                           i_pix,
    cv3_result_if.source                        o_res
);
    import cv3_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WBITS = $clog2(MAX_WIDTH + 1);
    localparam int HBITS = $clog2(MAX_HEIGHT + 1);

    // configuration
    logic [CFG_DATA_W-1:0] r_kern [0:KERNEL_DIM-1];
    logic [DIM_W-1:0]      r_frame_width;
    logic [DIM_W-1:0]      r_frame_height;
    logic [WBITS-1:0]      w_eff;
    logic [HBITS-1:0]      h_eff;
    logic                  cfg_size_wr;

    // counters
    logic [CW-1:0] r_col, n_col, c_cur;
    logic [RW-1:0] r_row, n_row, r_cur;
    logic          c_last, r_last;

    // handshake
    logic accept, f1, f2, f3, adv1, adv2;

    // stage 1: RAM read data pending
    logic               r_v1, r_prod1, r_done1;
    logic [PIXEL_W-1:0] r_px1;
    logic [CW-1:0]      r_addr1;
    logic [2*PIXEL_W-1:0] ram_rdata;

    // window
    logic [PIXEL_W-1:0] r_win [0:TAPS-1];
    logic [PIXEL_W-1:0] n_win [0:TAPS-1];

    // stage 2: products
    logic                       r_v2, r_done2;
    logic signed [PIXEL_W+COEF_W:0]  n_mul  [0:TAPS-1];
    logic signed [RESULT_W-1:0]      r_prod [0:TAPS-1];
    logic [RESULT_W-1:0]             n_sum;

    // stage 3: output register
    logic                       r_v3, r_done3;
    logic signed [RESULT_W-1:0] r_filt;

    always_comb begin
        if (int'(r_frame_width) < MIN_DIM) begin
            w_eff = WBITS'(MIN_DIM);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WBITS'(MAX_WIDTH);
        end else begin
            w_eff = WBITS'(r_frame_width);
        end
        if (int'(r_frame_height) < MIN_DIM) begin
            h_eff = HBITS'(MIN_DIM);
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = HBITS'(MAX_HEIGHT);
        end else begin
            h_eff = HBITS'(r_frame_height);
        end
    end

    assign cfg_size_wr = i_cfg_we &&
                         ((t_cfg_idx'(i_cfg_idx) == CFG_FRAME_WIDTH) ||
                          (t_cfg_idx'(i_cfg_idx) == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KERNEL_DIM; i++) begin
                r_kern[i] <= '0;
            end
            r_frame_width  <= DIM_W'(DIM_RESET);
            r_frame_height <= DIM_W'(DIM_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KERNEL_TOP:   r_kern[0] <= i_cfg_wdata;
                CFG_KERNEL_MID:   r_kern[1] <= i_cfg_wdata;
                CFG_KERNEL_BOT:   r_kern[2] <= i_cfg_wdata;
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ready chain, output side first
    assign f3     = !r_v3 || o_res.ready;
    assign f2     = !r_v2 || f3;
    assign f1     = !r_v1 || f2;
    assign adv1   = r_v1 && f2;
    assign adv2   = r_v2 && f3;
    assign accept = i_pix.valid && f1;
    assign i_pix.ready = f1;

    always_comb begin
        c_cur  = (WBITS'(r_col) >= w_eff) ? '0 : r_col;
        r_cur  = (HBITS'(r_row) >= h_eff) ? '0 : r_row;
        c_last = (WBITS'(c_cur) == (w_eff - WBITS'(1)));
        r_last = (HBITS'(r_cur) == (h_eff - HBITS'(1)));
        n_col  = r_col;
        n_row  = r_row;
        if (cfg_size_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            n_col = c_last ? '0 : c_cur + CW'(1);
            if (c_last) begin
                n_row = r_last ? '0 : r_cur + RW'(1);
            end else begin
                n_row = r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line RAM: [15:8] row r-2, [7:0] row r-1
    cv3_ram #(
        .WIDTH (2 * PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (adv1),
        .i_waddr (r_addr1),
        .i_wdata ({ram_rdata[PIXEL_W-1:0], r_px1}),
        .i_re    (accept),
        .i_raddr (c_cur),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (accept) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px1   <= i_pix.pixel;
            r_addr1 <= c_cur;
            r_prod1 <= (r_cur >= RW'(2)) && (c_cur >= CW'(2));
            r_done1 <= r_last && c_last;
        end
    end

    always_comb begin
        for (int j = 0; j < KERNEL_DIM; j++) begin
            n_win[3*j]     = r_win[3*j + 1];
            n_win[3*j + 1] = r_win[3*j + 2];
        end
        n_win[2] = ram_rdata[2*PIXEL_W-1:PIXEL_W];
        n_win[5] = ram_rdata[PIXEL_W-1:0];
        n_win[8] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else if (adv1) begin
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < KERNEL_DIM; j++) begin
            for (int k = 0; k < KERNEL_DIM; k++) begin
                n_mul[3*j + k] = $signed(r_kern[j][COEF_W*k +: COEF_W])
                               * $signed({1'b0, n_win[3*j + k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv1) begin
            r_v2 <= r_prod1;
        end else if (adv2) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_prod1) begin
            for (int i = 0; i < TAPS; i++) begin
                r_prod[i] <= n_mul[i][RESULT_W-1:0];
            end
            r_done2 <= r_done1;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < TAPS; i++) begin
            n_sum = n_sum + r_prod[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv2) begin
            r_v3 <= 1'b1;
        end else if (o_res.ready) begin
            r_v3 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_filt  <= $signed(n_sum);
            r_done3 <= r_done2;
        end
    end

    assign o_res.valid      = r_v3;
    assign o_res.filtered   = r_filt;
    assign o_res.frame_done = r_done3;

endmodule

`default_nettype wire
